@@ rtl/vtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pkg: shared types and constants of the vertex transform
// Data and width constants used by the pipeline stages and the top level.
// ----------------------------------------------------------------------------
package vtp_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DW       = 32;
  // product of two 32-bit signed values
  localparam int unsigned PW       = 64;
  // divider: 32-bit dividend magnitude shifted up, unsigned
  localparam int unsigned NW       = 64;

  typedef struct packed {
    logic              project;
    logic signed [DW-1:0] c0;
    logic signed [DW-1:0] c1;
    logic signed [DW-1:0] c2;
    logic signed [DW-1:0] c3;
  } vec_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW+3:0] v);
    logic signed [PW+3:0] mx;
    logic signed [PW+3:0] mn;
    mx = (PW+4)'(signed'(33'sh0_7FFF_FFFF));
    mn = -mx - (PW+4)'(1);
    if (v > mx) return {1'b0, {(DW-1){1'b1}}};
    else if (v < mn) return {1'b1, {(DW-1){1'b0}}};
    else return v[DW-1:0];
  endfunction
endpackage

@@ rtl/vtp_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_mac: matrix product pipeline
// Multiply the point by four matrix columns in three stages: products,
// exact summed partials, then floor shift, translation add and saturation.
// ----------------------------------------------------------------------------
module vtp_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [vtp_pkg::DW-1:0]         px,
  input  logic signed [vtp_pkg::DW-1:0]         py,
  input  logic signed [vtp_pkg::DW-1:0]         pz,
  input  logic                                  proj,
  input  logic [vtp_pkg::NUM_REGS-1:0][vtp_pkg::REG_W-1:0] regs,
  output logic                                  out_valid,
  output vtp_pkg::vec_t                         out_vec
);
  localparam int unsigned PW = vtp_pkg::PW;
  localparam int unsigned DW = vtp_pkg::DW;

  // stage 1: twelve products
  logic                        v1;
  logic                        p1;
  logic signed [PW-1:0]        prod [3][4];
  logic signed [DW-1:0]        tr1  [4];
  // stage 2: exact sum
  logic                        v2;
  logic                        p2;
  logic signed [PW+1:0]        sum2 [4];
  logic signed [DW-1:0]        tr2  [4];

  function automatic logic signed [DW-1:0] ent(
      input logic [vtp_pkg::NUM_REGS-1:0][vtp_pkg::REG_W-1:0] r,
      input int unsigned row, input int unsigned col);
    logic [vtp_pkg::REG_W-1:0] w;
    w = r[row*2 + col/2];
    return (col % 2 == 1) ? w[2*DW-1:DW] : w[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // floor of total equals floor(sum of products) >> FRAC_BITS exactly
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= proj;
      for (int c = 0; c < 4; c++) begin
        prod[0][c] <= PW'(px) * PW'(ent(regs, 0, c));
        prod[1][c] <= PW'(py) * PW'(ent(regs, 1, c));
        prod[2][c] <= PW'(pz) * PW'(ent(regs, 2, c));
        tr1[c]     <= ent(regs, 3, c);
      end
      p2 <= p1;
      for (int c = 0; c < 4; c++) begin
        sum2[c] <= (PW+2)'(prod[0][c]) + (PW+2)'(prod[1][c]) + (PW+2)'(prod[2][c]);
        tr2[c]  <= tr1[c];
      end
      out_vec.project <= p2;
      out_vec.c0 <= vtp_pkg::sat32((PW+4)'(sum2[0] >>> FRAC_BITS) + (PW+4)'(tr2[0]));
      out_vec.c1 <= vtp_pkg::sat32((PW+4)'(sum2[1] >>> FRAC_BITS) + (PW+4)'(tr2[1]));
      out_vec.c2 <= vtp_pkg::sat32((PW+4)'(sum2[2] >>> FRAC_BITS) + (PW+4)'(tr2[2]));
      out_vec.c3 <= vtp_pkg::sat32((PW+4)'(sum2[3] >>> FRAC_BITS) + (PW+4)'(tr2[3]));
    end
  end
endmodule

@@ rtl/vtp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_div: pipelined perspective divider
// Restoring division of three components by w, a fixed number of quotient
// bits per stage, three lanes sharing each stage's divisor.
// ----------------------------------------------------------------------------
module vtp_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  vtp_pkg::vec_t                 in_vec,
  output logic                          out_valid,
  output logic signed [vtp_pkg::DW-1:0] ox,
  output logic signed [vtp_pkg::DW-1:0] oy,
  output logic signed [vtp_pkg::DW-1:0] oz,
  output logic signed [vtp_pkg::DW-1:0] ow,
  output logic                          ozero
);
  localparam int unsigned DW   = vtp_pkg::DW;
  localparam int unsigned QW   = DW + FRAC_BITS;   // quotient bits needed
  localparam int unsigned BPS  = 4;                // quotient bits per stage
  localparam int unsigned NST  = (QW + BPS - 1) / BPS;
  localparam int unsigned TW   = NST * BPS;
  localparam int unsigned RW   = DW + 1;

  typedef struct packed {
    logic              valid;
    logic              divide;
    logic              zero;
    logic [DW-1:0]     dmag;
    logic signed [DW-1:0] w;
    logic [2:0]        neg;
    logic [2:0][DW-1:0] raw;
    logic [2:0][TW-1:0] num;
    logic [2:0][RW-1:0] rem;
  } dstage_t;

  dstage_t st [NST+1];
  dstage_t s0;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [DW-1:0] satq(input logic [TW-1:0] q, input logic n);
    logic [TW:0] lim;
    lim = (TW+1)'({1'b1, {(DW-1){1'b0}}});
    if (n) begin
      if ({1'b0, q} >= lim) return {1'b1, {(DW-1){1'b0}}};
      return DW'(-q);
    end
    if ({1'b0, q} >= lim) return {1'b0, {(DW-1){1'b1}}};
    return q[DW-1:0];
  endfunction

  logic signed [DW-1:0] comp [3];
  assign comp[0] = in_vec.c0;
  assign comp[1] = in_vec.c1;
  assign comp[2] = in_vec.c2;

  always_comb begin
    s0 = '0;
    s0.valid  = in_valid;
    s0.w      = in_vec.c3;
    s0.zero   = in_vec.project && (in_vec.c3 == '0);
    s0.divide = in_vec.project && (in_vec.c3 != '0) &&
                (in_vec.c3 != DW'(1) << FRAC_BITS);
    s0.dmag   = mag(in_vec.c3);
    for (int k = 0; k < 3; k++) begin
      s0.raw[k] = comp[k];
      s0.neg[k] = comp[k][DW-1] ^ in_vec.c3[DW-1];
      s0.num[k] = TW'({mag(comp[k]), {FRAC_BITS{1'b0}}});
      s0.rem[k] = '0;
    end
  end

  assign st[0] = s0;

  // advance BPS restoring steps per register stage
  for (genvar g = 0; g < NST; g++) begin : g_stage
    dstage_t nx;
    always_comb begin
      logic [RW-1:0] r;
      logic [TW-1:0] n;
      nx = st[g];
      for (int k = 0; k < 3; k++) begin
        r = st[g].rem[k];
        n = st[g].num[k];
        for (int b = 0; b < BPS; b++) begin
          r = {r[RW-2:0], n[TW-1]};
          n = {n[TW-2:0], 1'b0};
          if (r >= RW'(st[g].dmag)) begin
            r = r - RW'(st[g].dmag);
            n[0] = 1'b1;
          end
        end
        nx.rem[k] = r;
        nx.num[k] = n;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) st[g+1].valid <= 1'b0;
      else if (adv) st[g+1].valid <= nx.valid;
      if (adv) begin
        st[g+1].divide <= nx.divide;
        st[g+1].zero   <= nx.zero;
        st[g+1].dmag   <= nx.dmag;
        st[g+1].w      <= nx.w;
        st[g+1].neg    <= nx.neg;
        st[g+1].raw    <= nx.raw;
        st[g+1].num    <= nx.num;
        st[g+1].rem    <= nx.rem;
      end
    end
  end

  assign out_valid = st[NST].valid;
  assign ow        = st[NST].w;
  assign ozero     = st[NST].zero;
  assign ox = st[NST].divide ? satq(st[NST].num[0], st[NST].neg[0]) : st[NST].raw[0];
  assign oy = st[NST].divide ? satq(st[NST].num[1], st[NST].neg[1]) : st[NST].raw[1];
  assign oz = st[NST].divide ? satq(st[NST].num[2], st[NST].neg[2]) : st[NST].raw[2];
endmodule

@@ rtl/vertex_transform_project_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_project_core: 4x4 vertex transform with perspective divide
// Row-vector times matrix in Q16.16, optional divide by w, saturated results.
// ----------------------------------------------------------------------------
// One vertex per cycle is accepted while the output is not stalled. A vertex
// passes the matrix multiply stages (products, sum, translate and saturate),
// then ceil((32+FRAC_BITS)/4) divider stages (4 quotient bits each, 12 at
// FRAC_BITS=16), then one output register. The whole pipeline stalls as a
// unit when the output register holds a result that is not taken. The
// matrix comes from eight 64-bit registers, written through cfg_we /
// cfg_index / cfg_data; write them only while no vertex is in flight.
// ----------------------------------------------------------------------------
module vertex_transform_project_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic        do_project,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic        zero_w
);
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [vtp_pkg::NUM_REGS-1:0][vtp_pkg::REG_W-1:0] regs;
  logic                 adv;
  logic                 mv;
  vtp_pkg::vec_t        mvec;
  logic                 dv;
  logic signed [31:0]   dx, dy, dz, dw;
  logic                 dz0;

  // hold the matrix; reset to identity
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= ONE;
      regs[1] <= '0;
      regs[2] <= ONE << 32;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= ONE;
      regs[6] <= '0;
      regs[7] <= ONE << 32;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // advance whenever the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid && in_ready),
    .px(point_x), .py(point_y), .pz(point_z), .proj(do_project),
    .regs(regs), .out_valid(mv), .out_vec(mvec)
  );

  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(mv), .in_vec(mvec),
    .out_valid(dv), .ox(dx), .oy(dy), .oz(dz), .ow(dw), .ozero(dz0)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x  <= dx;
      out_y  <= dy;
      out_z  <= dz;
      out_w  <= dw;
      zero_w <= dz0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_w |-> out_w == '0)
    else $error("zero flag with nonzero w");
endmodule

@@ dv/vertex_transform_project_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_project_core_tb: self-checking bench of the vertex transform
// Walks a directed stimulus table, then random vertices under a series of
// matrices, with random stalls on both channels. Every output transfer is
// compared field by field against its typed row or a fixed-point predictor.
// ----------------------------------------------------------------------------
module vertex_transform_project_core_tb;

  localparam int FRAC       = 16;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_LEN   = 300;
  localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] S_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN  = 32'sh8000_0000;

  // register map of the matrix, by index
  typedef enum logic [2:0] {
    ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
    ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
  } mtx_reg_e;

  // matrix settings used by the directed table
  typedef enum int {SET_IDENTITY, SET_ZERO_W, SET_PERSPECTIVE} mtx_set_e;

  typedef struct {
    logic signed [vtp_pkg::DW-1:0] x, y, z, w;
    logic                 zw;
  } vertex_res_t;

  typedef struct {
    mtx_set_e             set;
    logic signed [vtp_pkg::DW-1:0] px, py, pz;
    logic                 proj;
    logic                 typed;
    vertex_res_t          res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic do_project = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic zero_w;

  vertex_transform_project_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .do_project(do_project),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w), .zero_w(zero_w)
  );

  // matrix as the block should hold it, and the next one to load
  logic [63:0] mtx_model [vtp_pkg::NUM_REGS];
  logic [63:0] mtx_next  [vtp_pkg::NUM_REGS];

  vertex_res_t pending_vertices[$];
  vertex_res_t typed_res;
  logic        use_typed = 1'b0;
  int          mismatch_count = 0;
  int          cycles = 0;
  bit          quiet = 0;     // no idling on either side
  bit          hold_req = 0;  // receiver long hold-off request

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [31:0] mtx_entry(int row, int col);
    logic [63:0] r;
    r = mtx_model[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [67:0] v);
    if (v > 68'(S_MAX)) return S_MAX;
    if (v < 68'(S_MIN)) return S_MIN;
    return v[31:0];
  endfunction

  function automatic vertex_res_t transform_vertex(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic proj);
    logic signed [67:0] acc;
    longint pv [3];
    longint num;
    logic signed [31:0] c [4];
    vertex_res_t r;
    pv[0] = px; pv[1] = py; pv[2] = pz;
    for (int col = 0; col < 4; col++) begin
      acc = '0;
      // exact sum of products, floored to the fraction width
      for (int row = 0; row < 3; row++)
        acc += 68'(pv[row] * longint'(mtx_entry(row, col)));
      acc = (acc >>> FRAC) + 68'(mtx_entry(3, col));
      c[col] = clamp32(acc);
    end
    r.zw = 1'b0;
    if (proj) begin
      if (c[3] == 0) begin
        r.zw = 1'b1;
      end else if (c[3] != FX_ONE) begin
        for (int k = 0; k < 3; k++) begin
          num = longint'(c[k]) <<< FRAC;
          c[k] = clamp32(68'(num / longint'(c[3])));
        end
      end
    end
    r.x = c[0]; r.y = c[1]; r.z = c[2]; r.w = c[3];
    return r;
  endfunction

  // ------------------------------------------------------------ scoreboard
  always @(posedge clk) begin
    vertex_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && in_valid && in_ready)
      pending_vertices.push_back(use_typed ? typed_res :
        transform_vertex(point_x, point_y, point_z, do_project));
    if (!rst && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected output transfer x=%h y=%h z=%h w=%h", $time,
                 out_x, out_y, out_z, out_w);
        mismatch_count++;
      end else begin
        e = pending_vertices.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          mismatch_count++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          mismatch_count++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          mismatch_count++;
        end
        if (out_w !== e.w) begin
          $display("%0t: out_w expected %h actual %h", $time, e.w, out_w);
          mismatch_count++;
        end
        if (zero_w !== e.zw) begin
          $display("%0t: zero_w expected %b actual %b", $time, e.zw, zero_w);
          mismatch_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------- receiver
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off: let the pipeline fill and back up the input
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic wait_drained();
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load mtx_next into the block; call only with the pipeline empty.
  task automatic load_matrix();
    wait_drained();
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= mtx_reg_e'(i);
      cfg_data  <= mtx_next[i];
      @(posedge clk);
      mtx_model[i] = mtx_next[i];
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one vertex and hold it until the transfer.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    point_x    <= x;
    point_y    <= y;
    point_z    <= z;
    do_project <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic select_set(mtx_set_e s);
    mtx_next[ROW0_COLS01] = {32'h0, FX_ONE};
    mtx_next[ROW0_COLS23] = '0;
    mtx_next[ROW1_COLS01] = {FX_ONE, 32'h0};
    mtx_next[ROW1_COLS23] = '0;
    mtx_next[ROW2_COLS01] = '0;
    mtx_next[ROW2_COLS23] = {32'h0, FX_ONE};
    mtx_next[ROW3_COLS01] = '0;
    mtx_next[ROW3_COLS23] = {FX_ONE, 32'h0};
    // zero w: drop the w translation
    if (s == SET_ZERO_W) mtx_next[ROW3_COLS23] = '0;
    // perspective: w follows z
    if (s == SET_PERSPECTIVE) begin
      mtx_next[ROW2_COLS23] = {FX_ONE, FX_ONE};
      mtx_next[ROW3_COLS23] = '0;
    end
  endtask

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return 32'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
      1: return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      4, 5, 6:    return $urandom;
      7:          return S_MAX;
      8:          return S_MIN;
      default:    return 32'($urandom_range(0, 7)) - 32'sd3;
    endcase
  endfunction

  stim_row_t stim_rows [$];

  function automatic stim_row_t mk_row(mtx_set_e s, logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic p, logic typed);
    stim_row_t r;
    r.set = s; r.px = x; r.py = y; r.pz = z; r.proj = p; r.typed = typed;
    // identity passes the point through with w of one; zero w flags on project
    r.res.x = x; r.res.y = y; r.res.z = z;
    r.res.w = (s == SET_IDENTITY) ? FX_ONE : 32'sh0;
    r.res.zw = (s == SET_ZERO_W) ? p : 1'b0;
    return r;
  endfunction

  initial begin
    mtx_set_e cur_set;
    int mode;
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) mtx_model[i] = '0;
    mtx_model[ROW0_COLS01] = {32'h0, FX_ONE};
    mtx_model[ROW1_COLS01] = {FX_ONE, 32'h0};
    mtx_model[ROW2_COLS23] = {32'h0, FX_ONE};
    mtx_model[ROW3_COLS23] = {FX_ONE, 32'h0};

    // directed rows: extremes after reset, zero w, then perspective divides
    stim_rows.push_back(mk_row(SET_IDENTITY, 0, 0, 0, 0, 1));
    stim_rows.push_back(mk_row(SET_IDENTITY, S_MAX, S_MAX, S_MAX, 1, 1));
    stim_rows.push_back(mk_row(SET_IDENTITY, S_MIN, S_MIN, S_MIN, 1, 1));
    stim_rows.push_back(mk_row(SET_IDENTITY, S_MAX, S_MIN, -1, 0, 1));
    stim_rows.push_back(mk_row(SET_IDENTITY, -1, 1, FX_ONE, 1, 1));
    stim_rows.push_back(mk_row(SET_IDENTITY, 32'h5555_5555, 32'hAAAA_AAAA, 7, 0, 1));
    stim_rows.push_back(mk_row(SET_ZERO_W, 123, -456, 789, 1, 1));
    stim_rows.push_back(mk_row(SET_ZERO_W, S_MAX, S_MIN, 0, 1, 1));
    stim_rows.push_back(mk_row(SET_ZERO_W, S_MIN, S_MAX, -1, 0, 1));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, FX_ONE, FX_ONE, 0, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, 3 * FX_ONE, -FX_ONE, FX_ONE, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, 3 * FX_ONE, -FX_ONE, 2 * FX_ONE, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, 5 * FX_ONE, 7, -3 * FX_ONE, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, S_MAX, S_MIN, 1, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, S_MIN, S_MAX, -1, 1, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, 12345, -9876, 3 * FX_ONE, 0, 0));
    stim_rows.push_back(mk_row(SET_PERSPECTIVE, S_MAX, S_MAX, S_MAX, 1, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = SET_IDENTITY;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].set != cur_set) begin
        end_burst();
        cur_set = stim_rows[i].set;
        select_set(cur_set);
        load_matrix();
      end
      // update at the edge, so the scoreboard sees the row that is transferred
      use_typed <= stim_rows[i].typed;
      typed_res <= stim_rows[i].res;
      send_point(stim_rows[i].px, stim_rows[i].py, stim_rows[i].pz, stim_rows[i].proj);
    end
    end_burst();
    use_typed <= 1'b0;

    // random phases: saturating extremes, zeros and all-ones, then random matrices
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
        case (ph)
          0: mtx_next[i] = {S_MAX, S_MAX};
          1: mtx_next[i] = {S_MIN, S_MIN};
          2: mtx_next[i] = '0;
          3: mtx_next[i] = '1;
          default: begin
            mode = (ph % 3 == 0) ? 1 : (($urandom_range(0, 9) == 0) ? 2 : 0);
            mtx_next[i] = {rand_entry(mode), rand_entry(mode)};
          end
        endcase
      end
      if (ph == 11) quiet = 1;
      load_matrix();
      if (ph == 5) hold_req = 1;
      for (int n = 0; n < 155; n++) begin
        if (ph == 7 && n == 70) begin
          // sender pause until the pipeline has drained
          end_burst();
          while (pending_vertices.size() != 0) @(posedge clk);
        end
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 3) != 0);
      end
      end_burst();
    end

    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
